### rtl/ils_pkg.sv
// Shared definitions for the indexed list store: sizes, request kinds, status codes
// and the request and result transaction types.
// No dependencies; indexed_list_store_core imports this package.
package ils_pkg;

    // Store size, the address width that follows from it, and the other field widths.
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 9;
    localparam int POS_W    = 9;
    localparam int KIND_W   = 3;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_READ      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INS_BACK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INS_POS   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELETE    = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // One request transaction.
    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [STAT_W-1:0]       status;
        logic [CNT_W-1:0]        count;
    } t_out_item;

endpackage

### rtl/ils_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/indexed_list_store_core.sv
// Indexed list store core: an ordered list of signed 32-bit values kept in one RAM.
// Depends on ils_pkg and ils_ram.
//
// The block takes one request at a time and returns one result per request. A read
// returns the element from S_READ, and rejected requests finish in S_IDLE. An insert
// that has to move elements passes through S_SHIFT, S_LAST and S_PLACE, and one that
// appends goes straight to S_PLACE. A delete passes through S_SHIFT and S_LAST, or
// finishes in S_IDLE when it removes the last element. Inserts and deletes move the
// later elements one place per cycle through the single read port and single write
// port of the element RAM. The worst case is an insert at the front of a list of 255
// elements, which moves all 255. A stalled output holds the finished result in S_RESP
// until there is room. A result waiting in the output register does not stop the next
// request from being accepted and started. The element RAM is not cleared after reset;
// only entries below the current count are ever read.
module indexed_list_store_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ils_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ils_pkg::t_out_item o_out_item
);
    import ils_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_LAST,
        S_PLACE,
        S_RESP
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [ADDR_W-1:0]      r_addr, n_addr;
    logic [ADDR_W-1:0]      r_stop, n_stop;
    logic [ADDR_W-1:0]      r_pos, n_pos;
    logic                   r_is_ins, n_is_ins;
    logic                   r_pend, n_pend;
    logic [ADDR_W-1:0]      r_pend_addr, n_pend_addr;
    logic signed [VAL_W-1:0] r_value, n_value;
    t_out_item              r_res, n_res;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out_item, n_out_item;

    logic                   ram_wr_en;
    logic [ADDR_W-1:0]      ram_wr_addr;
    logic [VAL_W-1:0]       ram_wr_data;
    logic                   ram_rd_en;
    logic [ADDR_W-1:0]      ram_rd_addr;
    logic [VAL_W-1:0]       ram_rd_data;

    logic                   accept;
    logic                   out_free;
    logic [CNT_W-1:0]       ins_pos;
    logic [CNT_W-1:0]       count_dec;
    logic                   fin;
    t_out_item              fin_item;

    // Element RAM.
    ils_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Handshake helpers and the insert position of the incoming request.
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign count_dec  = r_count - CNT_W'(1);

    always_comb begin
        unique case (i_in_item.kind)
            KIND_INS_FRONT: ins_pos = '0;
            KIND_INS_BACK:  ins_pos = r_count;
            default:        ins_pos = i_in_item.position;
        endcase
    end

    // Sequencer: request decode, element shifting and result completion.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_stop      = r_stop;
        n_pos       = r_pos;
        n_is_ins    = r_is_ins;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_value     = r_value;
        n_res       = r_res;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_pos;
        ram_wr_data = r_value;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_addr;
        fin         = 1'b0;
        fin_item    = '{read_value: '0, status: ST_DONE, count: r_count};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pend  = 1'b0;
                    n_value = i_in_item.value;
                    unique case (i_in_item.kind)
                        KIND_READ: begin
                            if (i_in_item.position < r_count) begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = i_in_item.position[ADDR_W-1:0];
                                n_state     = S_READ;
                            end else begin
                                fin             = 1'b1;
                                fin_item.status = ST_RANGE;
                            end
                        end
                        KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_POS: begin
                            if (ins_pos > r_count) begin
                                fin             = 1'b1;
                                fin_item.status = ST_RANGE;
                            end else if (r_count == CNT_W'(CAPACITY)) begin
                                fin             = 1'b1;
                                fin_item.status = ST_FULL;
                            end else begin
                                n_count  = r_count + CNT_W'(1);
                                n_is_ins = 1'b1;
                                n_pos    = ins_pos[ADDR_W-1:0];
                                if (ins_pos == r_count) begin
                                    n_state = S_PLACE;
                                end else begin
                                    n_addr  = count_dec[ADDR_W-1:0];
                                    n_stop  = ins_pos[ADDR_W-1:0];
                                    n_state = S_SHIFT;
                                end
                            end
                        end
                        KIND_DELETE: begin
                            if (i_in_item.position < r_count) begin
                                n_count  = count_dec;
                                n_is_ins = 1'b0;
                                if (i_in_item.position == count_dec) begin
                                    fin            = 1'b1;
                                    fin_item.count = count_dec;
                                end else begin
                                    n_addr  = ADDR_W'(i_in_item.position + POS_W'(1));
                                    n_stop  = count_dec[ADDR_W-1:0];
                                    n_state = S_SHIFT;
                                end
                            end else begin
                                fin             = 1'b1;
                                fin_item.status = ST_RANGE;
                            end
                        end
                        default: begin
                            fin             = 1'b1;
                            fin_item.status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_READ: begin
                fin                 = 1'b1;
                fin_item.read_value = $signed(ram_rd_data);
            end
            S_SHIFT: begin
                // Read the next element while the one read last cycle is written back.
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_addr;
                n_pend      = 1'b1;
                n_pend_addr = r_addr;
                if (r_pend) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_is_ins ? r_pend_addr + ADDR_W'(1)
                                           : r_pend_addr - ADDR_W'(1);
                    ram_wr_data = ram_rd_data;
                end
                if (r_addr == r_stop) begin
                    n_state = S_LAST;
                end else begin
                    n_addr = r_is_ins ? r_addr - ADDR_W'(1) : r_addr + ADDR_W'(1);
                end
            end
            S_LAST: begin
                // Write back the final moved element.
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_is_ins ? r_pend_addr + ADDR_W'(1)
                                       : r_pend_addr - ADDR_W'(1);
                ram_wr_data = ram_rd_data;
                n_pend      = 1'b0;
                if (r_is_ins) begin
                    n_state = S_PLACE;
                end else begin
                    fin = 1'b1;
                end
            end
            S_PLACE: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_pos;
                ram_wr_data = r_value;
                fin         = 1'b1;
            end
            S_RESP: begin
                fin      = 1'b1;
                fin_item = r_res;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Hand a finished result to the output register, or hold it until there is room.
        if (fin) begin
            if (out_free) begin
                n_state = S_IDLE;
            end else begin
                n_state = S_RESP;
                n_res   = fin_item;
            end
        end
    end

    // Output register.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        if (fin && out_free) begin
            n_out_valid = 1'b1;
            n_out_item  = fin_item;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_addr      <= n_addr;
        r_stop      <= n_stop;
        r_pos       <= n_pos;
        r_is_ins    <= n_is_ins;
        r_pend_addr <= n_pend_addr;
        r_value     <= n_value;
        r_res       <= n_res;
        r_out_item  <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTH
    // The element count never exceeds the store capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    // The count changes only right after a request is accepted.
    a_count_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> $past(accept))
        else $error("element count changed without a request");

    // A shift never reads and writes the same entry in one cycle.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
        else $error("read and write to the same entry");

    // A held result is presented as soon as the output register frees up.
    a_resp_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("held result not delivered");
`endif

endmodule
